### src/fsle_pkg.sv
// Shared types, constants and helpers of the framed serial link engine.
// Has no dependencies; every other file of the block imports it.
`default_nettype none

package fsle_pkg;

  // Payload widths on the stream ports.
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Command queue between the front and the back part.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Transmitted command frame.
  localparam int unsigned TX_FRAME_LEN = 21;
  localparam int unsigned TX_IDX_W     = 5;
  localparam logic [7:0]  TX_SYNC0     = 8'h66;
  localparam logic [7:0]  TX_SYNC1     = 8'h99;
  localparam logic [7:0]  TEMP_OFFSET  = 8'd40;
  localparam int unsigned TX_POS_SYNC1 = 1;
  localparam int unsigned TX_POS_SET   = 2;
  localparam int unsigned TX_POS_SENS  = 3;
  localparam int unsigned TX_POS_FAN   = 4;
  localparam int unsigned TX_POS_POWER = 5;
  localparam int unsigned TX_POS_SUM   = TX_FRAME_LEN - 1;

  // Received peer frame.
  localparam logic [7:0]  RX_SYNC0       = 8'h55;
  localparam logic [7:0]  RX_SYNC1       = 8'h5A;
  localparam logic [7:0]  RX_SYNC_SUM    = RX_SYNC0 + RX_SYNC1;
  localparam int unsigned RX_IDX_W       = 6;
  localparam int unsigned RX_POS_FIRST   = 2;
  localparam int unsigned RX_POS_VERSION = 2;
  localparam int unsigned RX_POS_TYPE    = 3;
  localparam int unsigned RX_POS_FAULT   = 9;
  localparam int unsigned RX_POS_SUM     = 32;

  // Highest mode index that maps to its own code.
  localparam logic [2:0] MODE_MAX = 3'd3;

  // Register reset values.
  localparam logic [15:0] TX_PERIOD_RST    = 16'd150;
  localparam logic [15:0] LOSS_TIMEOUT_RST = 16'd5000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TX_PERIOD    = 1'b0,
    CFG_LOSS_TIMEOUT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    KIND_TX    = 2'd0,
    KIND_RX_OK = 2'd1,
    KIND_LOST  = 2'd2
  } result_kind_e;

  typedef enum logic [1:0] {
    ST_HUNT   = 2'd0,
    ST_SECOND = 2'd1,
    ST_BODY   = 2'd2
  } sync_state_e;

  // Link status as it stands after the step that caused a result.
  typedef struct packed {
    logic       lost;
    logic [7:0] fault;
    logic [7:0] version;
    logic [7:0] ptype;
    logic       seen;
  } link_status_t;

  // The variable bytes of one command frame, plus its checksum.
  typedef struct packed {
    logic [7:0] set_byte;
    logic [7:0] sens_byte;
    logic [7:0] fan_mode_byte;
    logic       power;
    logic [7:0] sum;
  } tx_frame_t;

  // One queue entry: an optional command frame, then an optional event.
  typedef struct packed {
    logic         has_tx;
    logic         has_ev;
    result_kind_e ev_kind;
    tx_frame_t    frame;
    link_status_t status;
  } link_cmd_t;

  // Mode index to the code carried in the low bits of the fan byte.
  function automatic logic [1:0] mode_code(input logic [1:0] mode);
    logic [1:0] code;
    case (mode)
      2'd0:    code = 2'd3;
      2'd1:    code = 2'd0;
      2'd2:    code = 2'd2;
      default: code = 2'd1;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

### src/framed_serial_link_engine_core.sv
// Top level of the framed serial link engine: front part, command queue and
// back part. Depends on fsle_pkg, fsle_front, fsle_queue and fsle_back.
//
//   Channel  Direction  Handshake                     Payload
//   s_axis   in         s_axis_tvalid/s_axis_tready   tuser req_type, tdata item fields
//   m_axis   out        m_axis_tvalid/m_axis_tready   tuser kind, tlast, tdata result
//   cfg      in         cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// The front part takes one input item every cycle while the four-entry command
// queue has room; it updates all link state in that cycle.
// Each result costs one output transfer: a tick that sends a frame queues 21
// transfers, or 22 with a loss event, so the output channel sets the rate.
// Reset clears all control and link state at once; there is no clearing pass.
// A stall on the output backs up the queue, and only a full queue stalls input.
// Configuration writes are always taken and act on the next item.
`default_nettype none

module framed_serial_link_engine_core import fsle_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Input items.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata from bit 0: rx_data[7:0], power_on, op_mode[2:0], fan_level[3:0],
  // setpoint_c[7:0], sensor_ready, sensor_c[8:0] (signed), zero fill.
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: req_type (0 received byte, 1 tick).
  input  wire logic [0:0]            s_axis_tuser,
  // Result items.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata from bit 0: tx_data[7:0], link_lost, fault_code[7:0],
  // peer_version[7:0], peer_type[7:0], have_frame, zero fill.
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // tuser: result_kind (0 transmit byte, 1 frame received, 2 link lost).
  output logic [1:0]                 m_axis_tuser,
  output logic                       m_axis_tlast,
  // Configuration writes.
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic      q_full, q_empty, push, pop;
  link_cmd_t cmd, head;

  // Register writes never wait.
  assign cfg_ready_o = 1'b1;

  // Front part: classifies each item and updates the link state.
  fsle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_user_i   (s_axis_tuser[0]),
    .in_data_i   (s_axis_tdata),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  // Queue that lets the two parts stall independently.
  fsle_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  // Back part: turns each command into its sequence of result transfers.
  fsle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

### src/fsle_front.sv
// Front part: configuration registers, receive sync hunting and checksum,
// transmit pacing and loss timer. Emits one command per producing item.
// Depends on fsle_pkg.
`default_nettype none

module fsle_front import fsle_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  in_user_i,
  input  wire logic [IN_DATA_W-1:0]  in_data_i,
  input  wire logic                  q_full_i,
  output logic                       push_o,
  output link_cmd_t                  cmd_o
);

  logic [15:0] period_q, timeout_q;
  sync_state_e state_q, state_d;
  logic [RX_IDX_W-1:0] rx_idx_q;
  logic [7:0] rx_sum_q, ver_hold_q, type_hold_q, fault_hold_q;
  logic [15:0] tx_cnt_q, tx_cnt_d, loss_cnt_q, loss_cnt_d;
  link_status_t status_q, status_d;

  logic       accept, is_byte, is_tick;
  logic [7:0] rx_byte;
  logic       power;
  logic [2:0] op_mode;
  logic [3:0] fan;
  logic [7:0] setp;
  logic       sens_ready;
  logic [8:0] sensor;

  logic        frame_end, frame_good, sync_hit;
  logic [15:0] tx_inc, loss_inc;
  logic        send, loss_run, loss_fire;
  logic [1:0]  mode_eff;
  logic [4:0]  fan_inc;
  tx_frame_t   frame;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_byte    = accept && (req_type_e'(in_user_i) == REQ_BYTE);
  assign is_tick    = accept && (req_type_e'(in_user_i) == REQ_TICK);

  // tdata fields, lowest bits first.
  assign rx_byte    = in_data_i[7:0];
  assign power      = in_data_i[8];
  assign op_mode    = in_data_i[11:9];
  assign fan        = in_data_i[15:12];
  assign setp       = in_data_i[23:16];
  assign sens_ready = in_data_i[24];
  assign sensor     = in_data_i[33:25];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= TX_PERIOD_RST;
      timeout_q <= LOSS_TIMEOUT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_TX_PERIOD:    period_q  <= cfg_data_i;
        CFG_LOSS_TIMEOUT: timeout_q <= cfg_data_i;
      endcase
    end
  end

  // Sync state machine: next state.
  always_comb begin
    state_d = state_q;
    if (is_byte) begin
      unique case (state_q)
        ST_HUNT: begin
          if (rx_byte == RX_SYNC0) state_d = ST_SECOND;
        end
        ST_SECOND: begin
          if (rx_byte == RX_SYNC1) state_d = ST_BODY;
          else if (rx_byte != RX_SYNC0) state_d = ST_HUNT;
        end
        ST_BODY: begin
          if (rx_idx_q == RX_IDX_W'(RX_POS_SUM)) state_d = ST_HUNT;
        end
        default: state_d = ST_HUNT;
      endcase
    end
  end

  // Sync state machine: outputs.
  always_comb begin
    sync_hit   = 1'b0;
    frame_end  = 1'b0;
    unique case (state_q)
      ST_SECOND: sync_hit  = is_byte && (rx_byte == RX_SYNC1);
      ST_BODY:   frame_end = is_byte && (rx_idx_q == RX_IDX_W'(RX_POS_SUM));
      default: ;
    endcase
    frame_good = frame_end && (rx_sum_q == rx_byte);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_HUNT;
    else         state_q <= state_d;
  end

  // Frame body: running sum of bytes before the checksum and the fields kept.
  always_ff @(posedge clk_i) begin
    if (sync_hit) begin
      rx_idx_q <= RX_IDX_W'(RX_POS_FIRST);
      rx_sum_q <= RX_SYNC_SUM;
    end else if (is_byte && state_q == ST_BODY) begin
      rx_idx_q <= rx_idx_q + RX_IDX_W'(1);
      rx_sum_q <= rx_sum_q + rx_byte;
      if (rx_idx_q == RX_IDX_W'(RX_POS_VERSION)) ver_hold_q   <= rx_byte;
      if (rx_idx_q == RX_IDX_W'(RX_POS_TYPE))    type_hold_q  <= rx_byte;
      if (rx_idx_q == RX_IDX_W'(RX_POS_FAULT))   fault_hold_q <= rx_byte;
    end
  end

  // Tick pacing and loss timer.
  assign tx_inc    = tx_cnt_q + 16'd1;
  assign send      = tx_inc >= period_q;
  assign loss_run  = loss_cnt_q < timeout_q;
  assign loss_inc  = loss_cnt_q + 16'd1;
  assign loss_fire = loss_run && (loss_inc >= timeout_q) && !status_q.lost;

  always_comb begin
    tx_cnt_d   = tx_cnt_q;
    loss_cnt_d = loss_cnt_q;
    status_d   = status_q;
    if (is_tick) begin
      tx_cnt_d = send ? 16'd0 : tx_inc;
      if (loss_run)  loss_cnt_d    = loss_inc;
      if (loss_fire) status_d.lost = 1'b1;
    end else if (frame_good) begin
      loss_cnt_d       = 16'd0;
      status_d.lost    = 1'b0;
      status_d.version = ver_hold_q;
      status_d.ptype   = type_hold_q;
      status_d.fault   = fault_hold_q;
      status_d.seen    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_cnt_q   <= '0;
      loss_cnt_q <= '0;
      status_q   <= '0;
    end else begin
      tx_cnt_q   <= tx_cnt_d;
      loss_cnt_q <= loss_cnt_d;
      status_q   <= status_d;
    end
  end

  // Command frame contents from the operator settings carried by the tick.
  assign mode_eff = (op_mode > MODE_MAX) ? 2'd0 : op_mode[1:0];
  assign fan_inc  = {1'b0, fan} + 5'd1;

  always_comb begin
    frame.set_byte      = setp + TEMP_OFFSET;
    frame.sens_byte     = sens_ready ? (sensor[7:0] + TEMP_OFFSET) : frame.set_byte;
    frame.fan_mode_byte = {(power ? fan_inc[3:0] : 4'd0), 2'b00, mode_code(mode_eff)};
    frame.power         = power;
    frame.sum           = TX_SYNC0 + TX_SYNC1 + frame.set_byte + frame.sens_byte
                        + frame.fan_mode_byte + {7'd0, power};
  end

  always_comb begin
    cmd_o.has_tx  = is_tick && send;
    cmd_o.has_ev  = is_tick ? loss_fire : frame_good;
    cmd_o.ev_kind = is_tick ? KIND_LOST : KIND_RX_OK;
    cmd_o.frame   = frame;
    cmd_o.status  = status_d;
  end

  assign push_o = cmd_o.has_tx || cmd_o.has_ev;

endmodule

`default_nettype wire

### src/fsle_queue.sv
// Short command queue between the front and the back part.
// Depends on fsle_pkg.
`default_nettype none

module fsle_queue import fsle_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  link_cmd_t  data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output link_cmd_t  head_o
);

  link_cmd_t          entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]    count_q;

  assign full_o  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
        2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("command pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("command popped from an empty queue");
`endif

endmodule

`default_nettype wire

### src/fsle_back.sv
// Back part: expands queued commands into result transfers and holds them
// in the output register. Depends on fsle_pkg.
`default_nettype none

module fsle_back import fsle_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   empty_i,
  input  link_cmd_t                   head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [OUT_DATA_W-1:0]       out_data_o,
  output logic [1:0]                  out_user_o,
  output logic                        out_last_o
);

  logic [TX_IDX_W-1:0] idx_q, idx_d;
  logic                valid_q;
  logic [OUT_DATA_W-1:0] data_q;
  result_kind_e        kind_q;
  logic                last_q;

  logic         load, in_ev, last;
  logic [7:0]   tx_byte, data_byte;
  result_kind_e kind;

  // The frame bytes come first; the event, if any, follows them.
  assign in_ev = !head_i.has_tx || (idx_q == TX_IDX_W'(TX_FRAME_LEN));
  assign last  = in_ev || ((idx_q == TX_IDX_W'(TX_POS_SUM)) && !head_i.has_ev);
  assign load  = !empty_i && (!valid_q || out_ready_i);
  assign pop_o = load && last;

  always_comb begin
    if (idx_q == '0)                            tx_byte = TX_SYNC0;
    else if (idx_q == TX_IDX_W'(TX_POS_SYNC1))  tx_byte = TX_SYNC1;
    else if (idx_q == TX_IDX_W'(TX_POS_SET))    tx_byte = head_i.frame.set_byte;
    else if (idx_q == TX_IDX_W'(TX_POS_SENS))   tx_byte = head_i.frame.sens_byte;
    else if (idx_q == TX_IDX_W'(TX_POS_FAN))    tx_byte = head_i.frame.fan_mode_byte;
    else if (idx_q == TX_IDX_W'(TX_POS_POWER))  tx_byte = {7'd0, head_i.frame.power};
    else if (idx_q == TX_IDX_W'(TX_POS_SUM))    tx_byte = head_i.frame.sum;
    else                                        tx_byte = 8'd0;
  end

  assign kind      = in_ev ? head_i.ev_kind : KIND_TX;
  assign data_byte = in_ev ? 8'd0 : tx_byte;

  always_comb begin
    idx_d = idx_q;
    if (load) idx_d = last ? '0 : idx_q + TX_IDX_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load)             valid_q <= 1'b1;
      else if (out_ready_i) valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= {6'd0, head_i.status.seen, head_i.status.ptype, head_i.status.version,
                 head_i.status.fault, head_i.status.lost, data_byte};
      kind_q <= kind;
      last_q <= last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_user_o  = kind_q;
  assign out_last_o  = last_q;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= TX_IDX_W'(TX_FRAME_LEN))
    else $error("frame byte index out of range");
  a_mid_cmd_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0) |-> !empty_i)
    else $error("command left the queue before it was finished");
  a_event_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q != KIND_TX) |-> last_q)
    else $error("event result not marked last");
`endif

endmodule

`default_nettype wire

### dv/fsle_link_checker.sv
// Scoreboard for the framed serial link engine: watches the input, output and
// configuration channels, predicts the result stream and compares it.
// Depends on fsle_pkg for widths, codes and frame constants.

module fsle_link_checker import fsle_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_ready_i,
  input  wire logic [IN_DATA_W-1:0]  in_data_i,
  input  wire logic [0:0]            in_user_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_ready_i,
  input  wire logic [OUT_DATA_W-1:0] out_data_i,
  input  wire logic [1:0]            out_user_i,
  input  wire logic                  out_last_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic                  cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    result_kind_e kind;
    logic [7:0]   tx_byte;
    logic         last;
    logic         lost;
    logic [7:0]   fault;
    logic [7:0]   version;
    logic [7:0]   ptype;
    logic         seen;
  } link_result_t;

  // Mirror of the link state and the two registers.
  sync_state_e  rx_phase;
  logic [5:0]   rx_count;
  logic [7:0]   rx_bytes [RX_POS_SUM+1];
  logic [15:0]  tx_ticks;
  logic [15:0]  loss_ticks;
  logic [15:0]  tx_period;
  logic [15:0]  loss_timeout;
  logic         lost;
  logic         seen;
  logic [7:0]   fault;
  logic [7:0]   version;
  logic [7:0]   ptype;

  link_result_t link_results [$];
  link_result_t want;
  link_result_t got;
  int           reported;

  function automatic string describe(input link_result_t r);
    return $sformatf({"kind %0d data %02h last %0b lost %0b fault %02h ",
                      "version %02h type %02h seen %0b"},
                     r.kind, r.tx_byte, r.last, r.lost, r.fault, r.version, r.ptype, r.seen);
  endfunction

  // Advances the mirrored state by one input item and queues the results it causes.
  function automatic void predict_link_step(input req_type_e req,
                                            input logic [IN_DATA_W-1:0] d);
    result_kind_e kinds [$];
    logic [7:0]   bytes [$];
    logic [7:0]   frame [TX_FRAME_LEN];
    logic [7:0]   b;
    logic [7:0]   sum;
    logic [4:0]   fan_out;
    logic [1:0]   code;
    link_result_t r;
    int           i;

    b = d[7:0];
    if (req == REQ_BYTE) begin
      case (rx_phase)
        ST_HUNT: begin
          if (b == RX_SYNC0) begin
            rx_bytes[0] = b;
            rx_phase = ST_SECOND;
          end
        end
        ST_SECOND: begin
          if (b == RX_SYNC1) begin
            rx_bytes[1] = b;
            rx_count = 6'(RX_POS_FIRST);
            rx_phase = ST_BODY;
          end else if (b != RX_SYNC0) begin
            rx_phase = ST_HUNT;
          end else begin
            rx_bytes[0] = b;
          end
        end
        default: begin
          if (rx_count <= RX_POS_SUM) rx_bytes[rx_count] = b;
          rx_count = rx_count + 6'd1;
          if (rx_count > RX_POS_SUM || rx_count < RX_POS_FIRST) begin
            sum = '0;
            for (i = 0; i < RX_POS_SUM; i++) sum = sum + rx_bytes[i];
            if (sum == rx_bytes[RX_POS_SUM]) begin
              loss_ticks = '0;
              lost = 1'b0;
              version = rx_bytes[RX_POS_VERSION];
              ptype = rx_bytes[RX_POS_TYPE];
              fault = rx_bytes[RX_POS_FAULT];
              seen = 1'b1;
              kinds.push_back(KIND_RX_OK);
              bytes.push_back(8'h00);
            end
            rx_phase = ST_HUNT;
            rx_count = '0;
          end
        end
      endcase
    end else begin
      // Transmit pacing first, then the loss timer.
      tx_ticks = tx_ticks + 16'd1;
      if (tx_ticks >= tx_period) begin
        tx_ticks = '0;
        case (d[11:9])
          3'd1:    code = 2'd0;
          3'd2:    code = 2'd2;
          3'd3:    code = 2'd1;
          default: code = 2'd3;  // mode 0 and every mode above 3
        endcase
        fan_out = d[8] ? {1'b0, d[15:12]} + 5'd1 : 5'd0;
        for (i = 0; i < TX_FRAME_LEN; i++) frame[i] = '0;
        frame[0]            = TX_SYNC0;
        frame[TX_POS_SYNC1] = TX_SYNC1;
        frame[TX_POS_SET]   = d[23:16] + TEMP_OFFSET;
        frame[TX_POS_SENS]  = d[24] ? d[32:25] + TEMP_OFFSET : frame[TX_POS_SET];
        frame[TX_POS_FAN]   = {fan_out[3:0], 2'b00, code};
        frame[TX_POS_POWER] = {7'd0, d[8]};
        sum = '0;
        for (i = 0; i < TX_POS_SUM; i++) sum = sum + frame[i];
        frame[TX_POS_SUM] = sum;
        for (i = 0; i < TX_FRAME_LEN; i++) begin
          kinds.push_back(KIND_TX);
          bytes.push_back(frame[i]);
        end
      end
      if (loss_ticks < loss_timeout) begin
        loss_ticks = loss_ticks + 16'd1;
        if (loss_ticks >= loss_timeout && !lost) begin
          lost = 1'b1;
          kinds.push_back(KIND_LOST);
          bytes.push_back(8'h00);
        end
      end
    end

    // Every result of the step carries the status as it stands after the step.
    for (i = 0; i < kinds.size(); i++) begin
      r.kind    = kinds[i];
      r.tx_byte = bytes[i];
      r.last    = (i == kinds.size() - 1);
      r.lost    = lost;
      r.fault   = fault;
      r.version = version;
      r.ptype   = ptype;
      r.seen    = seen;
      link_results.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_phase = ST_HUNT;
      rx_count = '0;
      foreach (rx_bytes[i]) rx_bytes[i] = '0;
      tx_ticks = '0;
      loss_ticks = '0;
      tx_period = TX_PERIOD_RST;
      loss_timeout = LOSS_TIMEOUT_RST;
      lost = 1'b0;
      seen = 1'b0;
      fault = '0;
      version = '0;
      ptype = '0;
      link_results.delete();
      reported = 0;
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TX_PERIOD:    tx_period = cfg_data_i;
          CFG_LOSS_TIMEOUT: loss_timeout = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_link_step(req_type_e'(in_user_i[0]), in_data_i);
      if (out_valid_i && out_ready_i) begin
        got.kind    = result_kind_e'(out_user_i);
        got.tx_byte = out_data_i[7:0];
        got.last    = out_last_i;
        got.lost    = out_data_i[8];
        got.fault   = out_data_i[16:9];
        got.version = out_data_i[24:17];
        got.ptype   = out_data_i[32:25];
        got.seen    = out_data_i[33];
        if (link_results.size() == 0) begin
          fail_count_o++;
          if (reported < REPORT_LIMIT) $display("unexpected result: %s", describe(got));
          reported++;
        end else begin
          want = link_results.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (reported < REPORT_LIMIT) begin
              $display("result mismatch, expected: %s", describe(want));
              $display("                 actual:   %s", describe(got));
            end
            reported++;
          end
        end
      end
      pending_o = link_results.size();
    end
  end

endmodule

### dv/framed_serial_link_engine_core_tb.sv
// Testbench top for the framed serial link engine: clock, reset, stimulus and
// output back-pressure. Depends on fsle_pkg, the engine and fsle_link_checker.

module framed_serial_link_engine_core_tb;
  import fsle_pkg::*;

  localparam int CYCLE_LIMIT      = 1000000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 400;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [0:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int items_sent = 0;
  // Set by the stimulus to make the receiver hold off for that many cycles.
  int sink_hold_request = 0;
  // When set, the side concerned runs without idling until it toggles back.
  bit src_quiet = 1'b0;
  bit snk_quiet = 1'b0;

  framed_serial_link_engine_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  fsle_link_checker link_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_user_i   (m_axis_tuser),
    .out_last_i   (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Hard stop in case the engine hangs or drops results.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Idle cycles before the next transfer on one side. Every so often the side
  // flips into a stretch with no idling at all, and back.
  function automatic int draw_gap(inout bit quiet);
    if ($urandom_range(0, 31) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  // Packs the item fields into tdata, lowest field first.
  function automatic logic [IN_DATA_W-1:0] pack_item(input logic [7:0] rx, input logic power,
                                                     input logic [2:0] mode,
                                                     input logic [3:0] fan,
                                                     input logic [7:0] setp,
                                                     input logic ready,
                                                     input logic [8:0] sens);
    logic [IN_DATA_W-1:0] d;
    d        = '0;
    d[7:0]   = rx;
    d[8]     = power;
    d[11:9]  = mode;
    d[15:12] = fan;
    d[23:16] = setp;
    d[24]    = ready;
    d[33:25] = sens;
    return d;
  endfunction

  // All fields random within their ranges; the sensor spans -40 to 215.
  function automatic logic [IN_DATA_W-1:0] random_fields();
    logic [8:0] sens;
    sens = 9'($urandom_range(0, 255));
    sens = sens - 9'd40;
    return pack_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                     8'($urandom_range(0, 215)), 1'($urandom_range(0, 1)), sens);
  endfunction

  // Offers one item after a random gap and returns at the edge of its transfer.
  // The valid is only lowered when a gap follows, so back-to-back items keep it high.
  task automatic send_item(input req_type_e req, input logic [IN_DATA_W-1:0] d);
    int gap;
    gap = draw_gap(src_quiet);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // A received byte; the fields that only ticks use still carry random values.
  task automatic send_byte(input logic [7:0] b);
    logic [IN_DATA_W-1:0] d;
    d = random_fields();
    d[7:0] = b;
    send_item(REQ_BYTE, d);
  endtask

  // One peer frame with random content, ticks mixed in between its bytes. A bad
  // frame gets a checksum that is off by a random nonzero amount. Sometimes the
  // sync pair is preceded by an extra first sync byte, which must restart the pair.
  task automatic send_frame(input bit good);
    logic [7:0] frame_bytes [RX_POS_SUM+1];
    logic [7:0] sum;
    int         i;
    frame_bytes[0] = RX_SYNC0;
    frame_bytes[1] = RX_SYNC1;
    sum = RX_SYNC_SUM;
    for (i = RX_POS_FIRST; i < RX_POS_SUM; i++) begin
      frame_bytes[i] = 8'($urandom_range(0, 255));
      sum = sum + frame_bytes[i];
    end
    frame_bytes[RX_POS_SUM] = good ? sum : sum ^ 8'($urandom_range(1, 255));
    if ($urandom_range(0, 3) == 0) send_byte(RX_SYNC0);
    for (i = 0; i <= RX_POS_SUM; i++) begin
      if ($urandom_range(0, 5) == 0) send_item(REQ_TICK, random_fields());
      send_byte(frame_bytes[i]);
    end
  endtask

  // Mostly well-formed frames, some with bad sums, plus stray bytes and tick bursts.
  task automatic random_traffic(input int n);
    int target;
    int pick;
    target = items_sent + n;
    while (items_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        send_frame(1'b1);
      end else if (pick == 6) begin
        send_frame(1'b0);
      end else if (pick == 7) begin
        repeat ($urandom_range(1, 4))
          send_byte(($urandom_range(0, 3) == 0) ? RX_SYNC0 : 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) send_item(REQ_TICK, random_fields());
      end
    end
  endtask

  // Stops offering items and waits until every predicted result has been
  // transferred, then lets a few more cycles pass for items that cause none.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: after each result transfer it draws an idle gap. A hold request
  // from the stimulus overrides the gap and keeps tready low for a long stretch,
  // so the command queue fills and the input side stalls.
  initial begin : result_sink
    int hold;
    m_axis_tready = 1'b0;
    hold = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) hold = draw_gap(snk_quiet);
      if (sink_hold_request > 0) begin
        hold = sink_hold_request;
        sink_hold_request = 0;
      end
      @(negedge clk_i);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Two ticks at the reset period send nothing; the stray bytes
    // check that hunting ignores a lone second sync byte and both byte extremes.
    send_item(REQ_TICK, pack_item(8'h00, 1'b0, 3'd0, 4'd0, 8'd0, 1'b0, -9'sd40));
    send_item(REQ_TICK, pack_item(8'hFF, 1'b1, 3'd7, 4'd15, 8'd215, 1'b1, 9'd215));
    send_byte(RX_SYNC1);
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_drained();

    // A frame on every tick, loss declared on the sixth tick since reset.
    write_reg(CFG_TX_PERIOD, 16'd1);
    write_reg(CFG_LOSS_TIMEOUT, 16'd6);
    // Fan level 15 while powered wraps to a zero upper nibble; mode 7 maps as mode 0.
    send_item(REQ_TICK, pack_item(8'hFF, 1'b1, 3'd7, 4'd15, 8'd215, 1'b1, 9'd215));
    // Power off sends fan 0; sensor not ready repeats the setpoint byte.
    send_item(REQ_TICK, pack_item(8'h00, 1'b0, 3'd0, 4'd15, 8'd0, 1'b0, -9'sd40));
    send_item(REQ_TICK, pack_item(8'h5A, 1'b1, 3'd1, 4'd0, 8'd100, 1'b1, -9'sd40));
    send_item(REQ_TICK, pack_item(8'hA5, 1'b1, 3'd2, 4'd7, 8'd25, 1'b1, 9'd0));
    send_item(REQ_TICK, pack_item(8'h55, 1'b0, 3'd3, 4'd8, 8'd215, 1'b0, 9'd215));
    send_item(REQ_TICK, pack_item(8'h3C, 1'b1, 3'd4, 4'd1, 8'd60, 1'b1, 9'd127));
    send_item(REQ_TICK, pack_item(8'hC3, 1'b1, 3'd5, 4'd14, 8'd1, 1'b1, 9'd128));
    send_item(REQ_TICK, pack_item(8'h0F, 1'b0, 3'd6, 4'd3, 8'd2, 1'b0, -9'sd1));
    // Sync hunting: a non-sync byte after the first sync byte returns to hunting,
    // and a repeated first sync byte followed by junk does the same.
    send_byte(RX_SYNC0);
    send_byte(8'h13);
    send_byte(RX_SYNC0);
    send_byte(RX_SYNC0);
    send_byte(8'h21);
    wait_drained();

    // Heavy output load: the receiver holds off for a long stretch while ticks
    // keep coming, each worth a whole frame, so the queue fills and input stalls.
    write_reg(CFG_LOSS_TIMEOUT, 16'($urandom_range(20, 80)));
    sink_hold_request = LONG_HOLD_CYCLES;
    repeat (12) send_item(REQ_TICK, random_fields());
    random_traffic(50);
    wait_drained();

    // Longest period sends nothing; the shortest timeout signals loss on the
    // first tick after each good frame.
    write_reg(CFG_TX_PERIOD, 16'hFFFF);
    write_reg(CFG_LOSS_TIMEOUT, 16'd1);
    random_traffic(35);
    wait_drained();

    // Zero period sends on every tick; the longest timeout lets the loss count run.
    write_reg(CFG_TX_PERIOD, 16'd0);
    write_reg(CFG_LOSS_TIMEOUT, 16'hFFFF);
    random_traffic(25);
    wait_drained();

    // Timeout lowered, possibly below the running count: then no loss until a good frame.
    write_reg(CFG_TX_PERIOD, 16'd2);
    write_reg(CFG_LOSS_TIMEOUT, 16'd3);
    random_traffic(25);
    wait_drained();

    // Zero timeout never declares loss.
    write_reg(CFG_TX_PERIOD, 16'($urandom_range(1, 6)));
    write_reg(CFG_LOSS_TIMEOUT, 16'd0);
    random_traffic(25);
    wait_drained();

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### framed_serial_link_engine_core.f
src/fsle_pkg.sv
src/fsle_front.sv
src/fsle_queue.sv
src/fsle_back.sv
src/framed_serial_link_engine_core.sv
dv/fsle_link_checker.sv
dv/framed_serial_link_engine_core_tb.sv
